### sv/swc_pkg.sv
// ----------------------------------------------------------------------------
// Soil water content package
// Shared constants, types and the exponential table for the water retention
// pipeline.
// ----------------------------------------------------------------------------
package swc_pkg;

  localparam int unsigned CONTENT_FRAC_BITS = 16;
  localparam int unsigned CONTENT_W = 16;
  localparam int unsigned LOG_FB = 24;
  localparam int unsigned LOG_IN_W = 54;
  localparam int unsigned LOG_P_W = 6;
  localparam int unsigned LOG_OUT_W = LOG_P_W + LOG_FB;
  localparam int unsigned LOG_LAT = LOG_FB + 2;
  localparam int unsigned EXP_IN_W = 37;
  localparam int unsigned EXP_N_W = 6;
  localparam int unsigned EXP_OUT_W = 33;
  localparam int unsigned EXP_LAT = LOG_FB + 2;
  localparam int unsigned MIN_STEP = ((1 << CONTENT_FRAC_BITS) + 5000) / 10000;

  localparam logic [19:0] BETA_MIN = 20'd65537;
  localparam logic [53:0] OFFSET_CM = 54'd167772;

  localparam logic [1:0] REG_RESIDUAL = 2'd0;
  localparam logic [1:0] REG_SATURATED = 2'd1;
  localparam logic [1:0] REG_ALPHA = 2'd2;
  localparam logic [1:0] REG_BETA = 2'd3;

  typedef enum logic [1:0] {
    CASE_FORMULA = 2'd0,
    CASE_SAT     = 2'd1,
    CASE_RES     = 2'd2,
    CASE_FLOOR   = 2'd3
  } case_t;

  typedef struct packed {
    logic        busy;
    logic [23:0] gamma;
  } gdiv_stat_t;

  typedef logic [LOG_FB:0][31:0] exp_rom_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    n = n_in;
    r = '0;
    for (int k = 31; k >= 0; k--) begin
      b = 64'd1 << (2 * k);
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [63:0] cur;
    rom = '0;
    cur = isqrt64(64'd1 << 63);
    rom[1] = cur[31:0];
    for (int i = 2; i <= LOG_FB; i++) begin
      cur = isqrt64({cur[31:0], 32'd0});
      rom[i] = cur[31:0];
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

### sv/swc_log2.sv
// ----------------------------------------------------------------------------
// Pipelined base-2 logarithm
// Leading-one detect, normalize, then one squaring step per stage for each
// fraction bit. The result has LOG_FB fraction bits and is truncated.
// ----------------------------------------------------------------------------
module swc_log2 import swc_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [LOG_IN_W-1:0]  v,
  output logic [LOG_OUT_W-1:0] res
);

  logic [LOG_IN_W-1:0] va_r;
  logic [LOG_P_W-1:0]  pa_r;
  logic                za_r;
  logic [LOG_P_W-1:0]  pa_nxt;
  logic [LOG_IN_W-1:0] sh;

  logic [31:0]        m_r   [0:LOG_FB];
  logic [31:0]        m_nxt [0:LOG_FB];
  logic [LOG_FB-1:0]  f_r   [0:LOG_FB];
  logic [LOG_FB-1:0]  f_nxt [0:LOG_FB];
  logic [LOG_P_W-1:0] p_r   [0:LOG_FB];
  logic [LOG_P_W-1:0] p_nxt [0:LOG_FB];
  logic               z_r   [0:LOG_FB];
  logic               z_nxt [0:LOG_FB];
  logic [63:0]        sq    [1:LOG_FB];
  logic [32:0]        t     [1:LOG_FB];

  always_comb begin
    pa_nxt = '0;
    for (int i = 0; i < LOG_IN_W; i++) begin
      if (v[i]) begin
        pa_nxt = LOG_P_W'(i);
      end
    end
  end

  assign sh = va_r << (LOG_P_W'(LOG_IN_W - 1) - pa_r);

  always_comb begin
    m_nxt[0] = sh[LOG_IN_W-1 -: 32];
    f_nxt[0] = '0;
    p_nxt[0] = pa_r;
    z_nxt[0] = za_r;
    for (int i = 1; i <= LOG_FB; i++) begin
      sq[i] = m_r[i-1] * m_r[i-1];
      t[i] = sq[i][63:31];
      f_nxt[i] = f_r[i-1];
      p_nxt[i] = p_r[i-1];
      z_nxt[i] = z_r[i-1];
      if (t[i][32]) begin
        m_nxt[i] = t[i][32:1];
        f_nxt[i][LOG_FB-i] = 1'b1;
      end else begin
        m_nxt[i] = t[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      va_r <= v;
      pa_r <= pa_nxt;
      za_r <= (v == '0);
      for (int i = 0; i <= LOG_FB; i++) begin
        m_r[i] <= m_nxt[i];
        f_r[i] <= f_nxt[i];
        p_r[i] <= p_nxt[i];
        z_r[i] <= z_nxt[i];
      end
    end
  end

  assign res = z_r[LOG_FB] ? '0 : {p_r[LOG_FB], f_r[LOG_FB]};

endmodule

### sv/swc_exp2.sv
// ----------------------------------------------------------------------------
// Pipelined negative power of two
// Computes 2^-a for a with LOG_FB fraction bits as a Q1.32 value, one table
// product per fraction bit, then the integer shift.
// ----------------------------------------------------------------------------
module swc_exp2 import swc_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [EXP_IN_W-1:0]  a,
  output logic [EXP_OUT_W-1:0] v
);

  logic [EXP_OUT_W-1:0] v_r   [0:LOG_FB];
  logic [EXP_OUT_W-1:0] v_nxt [1:LOG_FB];
  logic [LOG_FB-1:0]    f_r   [0:LOG_FB];
  logic [EXP_N_W-1:0]   n_r   [0:LOG_FB];
  logic                 big_r [0:LOG_FB];
  logic [65:0]          pr    [1:LOG_FB];
  logic [EXP_OUT_W-1:0] out_r;

  always_comb begin
    for (int i = 1; i <= LOG_FB; i++) begin
      pr[i] = 66'(v_r[i-1]) * 66'(EXP_ROM[i]) + 66'(64'd1 << 31);
      if (f_r[i-1][LOG_FB-i]) begin
        v_nxt[i] = pr[i][64:32];
      end else begin
        v_nxt[i] = v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r[0] <= EXP_OUT_W'(64'd1 << 32);
      f_r[0] <= a[LOG_FB-1:0];
      n_r[0] <= a[LOG_FB +: EXP_N_W];
      big_r[0] <= (a[EXP_IN_W-1:LOG_FB] > 13'd32);
      for (int i = 1; i <= LOG_FB; i++) begin
        v_r[i] <= v_nxt[i];
        f_r[i] <= f_r[i-1];
        n_r[i] <= n_r[i-1];
        big_r[i] <= big_r[i-1];
      end
      out_r <= big_r[LOG_FB] ? '0 : (v_r[LOG_FB] >> n_r[LOG_FB]);
    end
  end

  assign v = out_r;

endmodule

### sv/swc_gamma_div.sv
// ----------------------------------------------------------------------------
// Exponent divider
// Serial restoring division that forms 1 - 1/beta with 24 fraction bits,
// rounded, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swc_gamma_div import swc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [19:0] beta,
  output gdiv_stat_t stat
);

  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [19:0] rem_r;
  logic [23:0] q_r;
  logic [23:0] gamma_r;
  logic [40:0] num;
  logic [20:0] sh;
  logic        qb;
  logic [19:0] rem_nxt;
  logic [23:0] q_nxt;
  logic [24:0] g_full;

  assign num = {1'b1, 21'd0, beta[19:1]};

  always_comb begin
    sh = {rem_r, num[cnt_r]};
    qb = (sh >= {1'b0, beta});
    rem_nxt = qb ? 20'(sh - {1'b0, beta}) : sh[19:0];
    q_nxt = {q_r[22:0], qb};
    g_full = 25'd1 << 24;
    g_full = g_full - {1'b0, q_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      busy_r <= 1'b1;
      cnt_r <= 6'd40;
      rem_r <= '0;
      q_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r <= q_nxt;
      if (cnt_r == 6'd0) begin
        busy_r <= 1'b0;
        gamma_r <= g_full[23:0];
      end else begin
        cnt_r <= cnt_r - 6'd1;
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.gamma = gamma_r;

endmodule

### sv/soil_water_content_from_potential.sv
// ----------------------------------------------------------------------------
// Soil water content from matric potential
// Van Genuchten water retention curve as a fully pipelined stream block.
// ----------------------------------------------------------------------------
// The block takes one potential per cycle while in_tready is high and returns
// one water content per request in order; the depth is set by the four chained
// logarithm and exponential pipelines, each with one squaring or table product
// per fraction bit. After reset and after every write of beta_coeff the input
// is held off while the serial divider forms the exponent 1 - 1/beta; other
// register writes take effect at once.
module soil_water_content_from_potential import swc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [43:0] potential
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] water_content, [17:16] case_taken
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int unsigned S_LOG1 = LOG_LAT;
  localparam int unsigned S_SUM = S_LOG1 + 1;
  localparam int unsigned S_MUL = S_SUM + 1;
  localparam int unsigned S_Y = S_MUL + 1;
  localparam int unsigned S_EXP1 = S_Y + EXP_LAT;
  localparam int unsigned S_LOG2 = S_EXP1 + LOG_LAT;
  localparam int unsigned S_L1 = S_LOG2 + 1;
  localparam int unsigned S_G = S_L1 + 1;
  localparam int unsigned S_EXP2 = S_G + EXP_LAT;
  localparam int unsigned S_LAST = S_EXP2 + 1;

  typedef struct packed {
    logic        valid;
    case_t       kind;
    logic [34:0] ypos;
  } side_t;

  logic [15:0] qr_r;
  logic [15:0] qs_r;
  logic [23:0] alpha_r;
  logic [19:0] beta_r;
  logic [19:0] beta_eff;
  gdiv_stat_t  gdiv;

  side_t side_r   [0:S_LAST];
  side_t side_nxt [0:S_LAST];

  logic adv;
  logic in_acc;

  logic signed [43:0] psi;
  logic [43:0]        negpsi;
  case_t              kind_in;
  logic [53:0]        x_r;

  logic [LOG_OUT_W-1:0] la;
  logic [LOG_OUT_W-1:0] lx;
  logic [LOG_OUT_W-1:0] lv;
  logic [EXP_OUT_W-1:0] ev1;
  logic [EXP_OUT_W-1:0] ev2;

  logic signed [30:0] s_r;
  logic signed [51:0] sb_full;
  logic signed [50:0] sb_r;
  logic signed [34:0] y;
  logic [34:0]        ay_r;
  logic [35:0]        l1_r;
  logic [59:0]        mg_r;
  logic [60:0]        e_full;
  logic [48:0]        pr_r;
  logic [32:0]        fac;

  logic        neg;
  logic [15:0] mag;
  logic [49:0] pr_rnd;
  logic [17:0] prod;
  logic signed [19:0] res;
  logic signed [19:0] floor_lvl;
  logic [15:0] content;
  case_t       kind_out;

  logic [17:0] p_data;
  logic        out_valid_r;
  logic [17:0] out_data_r;
  logic        skid_valid_r;
  logic [17:0] skid_data_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qr_r <= 16'd3277;
      qs_r <= 16'd29491;
      alpha_r <= 24'd335544;
      beta_r <= 20'd98304;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RESIDUAL:  qr_r <= cfg_data[15:0];
        REG_SATURATED: qs_r <= cfg_data[15:0];
        REG_ALPHA:     alpha_r <= cfg_data;
        REG_BETA:      beta_r <= cfg_data[19:0];
        default:       ;
      endcase
    end
  end

  assign beta_eff = (beta_r < BETA_MIN) ? BETA_MIN : beta_r;

  swc_gamma_div u_gdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_valid && (cfg_index == REG_BETA)),
    .beta  (beta_eff),
    .stat  (gdiv)
  );

  assign adv = !skid_valid_r;
  assign in_tready = adv && !gdiv.busy;
  assign in_acc = in_tvalid && in_tready;

  assign psi = $signed(in_tdata[43:0]);
  assign negpsi = -in_tdata[43:0];

  always_comb begin
    if (psi >= -44'sd167) begin
      kind_in = CASE_SAT;
    end else if (psi <= -44'sd8388608000000) begin
      kind_in = CASE_RES;
    end else begin
      kind_in = CASE_FORMULA;
    end
  end

  always_comb begin
    side_nxt[0].valid = in_acc;
    side_nxt[0].kind = kind_in;
    side_nxt[0].ypos = '0;
    for (int k = 1; k <= S_LAST; k++) begin
      side_nxt[k] = side_r[k-1];
    end
    side_nxt[S_Y].ypos = y[34] ? 35'd0 : 35'(y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= S_LAST; k++) begin
        side_r[k].valid <= 1'b0;
      end
    end else if (adv) begin
      for (int k = 0; k <= S_LAST; k++) begin
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign y = sb_r[50:16];
  assign e_full = {1'b0, mg_r} + 61'(64'd1 << 23);
  assign fac = (alpha_r == '0) ? 33'(64'd1 << 32) : ev2;
  assign sb_full = s_r * $signed({1'b0, beta_eff});

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r <= 54'(negpsi) * 54'd1000 - OFFSET_CM;
      s_r <= 31'(la) + 31'(lx) - (31'd48 << LOG_FB);
      sb_r <= sb_full[50:0];
      ay_r <= y[34] ? 35'(-y) : 35'(y);
      l1_r <= 36'(side_r[S_LOG2].ypos) + 36'(lv) - (36'd32 << LOG_FB);
      mg_r <= 60'(l1_r) * 60'(gdiv.gamma);
      pr_r <= 49'(mag) * 49'(fac);
    end
  end

  swc_log2 u_log_alpha (
    .clk (clk),
    .en  (adv),
    .v   (54'(alpha_r)),
    .res (la)
  );

  swc_log2 u_log_x (
    .clk (clk),
    .en  (adv),
    .v   (x_r),
    .res (lx)
  );

  swc_exp2 u_exp_y (
    .clk (clk),
    .en  (adv),
    .a   (37'(ay_r)),
    .v   (ev1)
  );

  swc_log2 u_log_sum (
    .clk (clk),
    .en  (adv),
    .v   (54'(ev1) + (54'd1 << 32)),
    .res (lv)
  );

  swc_exp2 u_exp_e (
    .clk (clk),
    .en  (adv),
    .a   (e_full[60:24]),
    .v   (ev2)
  );

  always_comb begin
    neg = (qs_r < qr_r);
    mag = neg ? (qr_r - qs_r) : (qs_r - qr_r);
    pr_rnd = {1'b0, pr_r} + 50'(64'd1 << 31);
    prod = pr_rnd[49:32];
    if (neg) begin
      res = $signed({4'd0, qr_r}) - $signed({2'd0, prod});
    end else begin
      res = $signed({4'd0, qr_r}) + $signed({2'd0, prod});
    end
    floor_lvl = $signed({4'd0, qr_r}) + $signed(20'(MIN_STEP));
    kind_out = CASE_FORMULA;
    if (res < floor_lvl) begin
      res = floor_lvl;
      kind_out = CASE_FLOOR;
    end
    if (res < 20'sd0) begin
      content = '0;
    end else if (res > 20'sd65535) begin
      content = 16'hFFFF;
    end else begin
      content = res[15:0];
    end
    case (side_r[S_LAST].kind)
      CASE_SAT: p_data = {CASE_SAT, qs_r};
      CASE_RES: p_data = {CASE_RES, qr_r};
      default:  p_data = {kind_out, content};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (!out_valid_r || out_tready) begin
        out_valid_r <= 1'b1;
        out_data_r <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (side_r[S_LAST].valid) begin
      if (!out_valid_r || out_tready) begin
        out_valid_r <= 1'b1;
        out_data_r <= p_data;
      end else begin
        skid_valid_r <= 1'b1;
        skid_data_r <= p_data;
      end
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {6'd0, out_data_r};

endmodule
